// ===== rtl/core/multi_reader_ring_buffer_assert.svh =====
// Assertion macros used by the top level of the multi-reader ring buffer.
`ifndef MULTI_READER_RING_BUFFER_ASSERT_SVH
`define MULTI_READER_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MRRB_CHK_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("multi_reader_ring_buffer: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MRRB_CHK_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("multi_reader_ring_buffer: next-cycle check failed");

`endif

// ===== rtl/core/mrrb_pkg.sv =====
// Package with constants, types and codes of the multi-reader ring buffer.
`default_nettype none
package mrrb_pkg;
	localparam int BUF_DEPTH      = 65536;
	localparam int ADDR_W         = $clog2(BUF_DEPTH);
	localparam int SIZE_W         = ADDR_W + 1;
	localparam int NUM_READERS    = 8;
	localparam int SEL_W          = 3;
	localparam int MAX_READ_BYTES = 512;
	localparam int LEN_W          = 10;
	localparam int BYTES_PER_WORD = 8;
	localparam int LANE_W         = $clog2(BYTES_PER_WORD);
	localparam int CNT_W          = 4;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	typedef enum logic [1:0] {
		RS_DATA  = 2'd0,
		RS_FIRST = 2'd1,
		RS_NONE  = 2'd2,
		RS_ZERO  = 2'd3
	} rd_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_LEN,
		ST_RD,
		ST_CAP,
		ST_EMIT,
		ST_STAT
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [7:0]       wr_byte;
		logic             wr_last;
		logic [SEL_W-1:0] reader_sel;
		logic [LEN_W-1:0] req_size;
		logic [LEN_W-1:0] align;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last;
		logic [31:0] total_count;
		logic [15:0] write_position;
	} out_item_t;

	typedef struct packed {
		logic       in_ready;
		logic       eval_load;
		logic       first_commit;
		logic       seen_upd;
		logic       div_start;
		logic       len_load;
		logic       set_stat;
		rd_status_t stat_code;
		logic       rd_issue;
		logic       cap;
		logic       emit_data;
		logic       emit_stat;
	} ctrl_cmd_t;

	typedef struct packed {
		logic read_req;
		logic is_first;
		logic no_new;
		logic al_zero;
		logic div_done;
		logic len_zero;
		logic n_full;
		logic rem_zero;
		logic out_free;
	} dp_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/mrrb_ifs.sv =====
// Channel interfaces of the multi-reader ring buffer: items, results, configuration.
`default_nettype none
interface mrrb_in_if;
	import mrrb_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mrrb_out_if;
	import mrrb_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mrrb_cfg_if;
	import mrrb_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mrrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mrrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/mrrb_div.sv =====
// Restoring divider that yields the remainder, one quotient bit per cycle.
`default_nettype none
module mrrb_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mrrb_pkg::LEN_W-1:0] dividend,
	input  logic [mrrb_pkg::LEN_W-1:0] divisor,
	output logic [mrrb_pkg::LEN_W-1:0] rem,
	output logic                       done
);
	import mrrb_pkg::*;

	localparam int STEP_W = $clog2(LEN_W + 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  quo_q;
	logic [LEN_W-1:0]  d_q;
	logic [LEN_W:0]    trial;
	logic [LEN_W:0]    diff;

	always_comb begin
		trial = {rem_q, quo_q[LEN_W-1]};
		diff  = trial - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= STEP_W'(LEN_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			d_q   <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[LEN_W-2:0], 1'b0};
			if (trial >= {1'b0, d_q}) begin
				rem_q <= diff[LEN_W-1:0];
			end else begin
				rem_q <= trial[LEN_W-1:0];
			end
		end
	end

	assign rem  = rem_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== rtl/core/mrrb_ctrl.sv =====
// Controller state machine that sequences reads, the alignment divide and result output.
`default_nettype none
module mrrb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  mrrb_pkg::dp_sts_t   sts,
	output mrrb_pkg::ctrl_cmd_t cmd
);
	import mrrb_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.stat_code = RS_DATA;
		state_nxt     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.read_req) begin
					state_nxt = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval_load = 1'b1;
				cmd.set_stat  = 1'b1;
				if (sts.is_first) begin
					cmd.first_commit = 1'b1;
					cmd.stat_code    = RS_FIRST;
					state_nxt        = ST_STAT;
				end else if (sts.no_new) begin
					cmd.stat_code = RS_NONE;
					state_nxt     = ST_STAT;
				end else begin
					cmd.seen_upd = 1'b1;
					if (sts.al_zero) begin
						state_nxt = ST_LEN;
					end else begin
						cmd.div_start = 1'b1;
						state_nxt     = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_nxt = ST_LEN;
				end
			end
			ST_LEN: begin
				cmd.len_load = 1'b1;
				if (sts.len_zero) begin
					cmd.set_stat  = 1'b1;
					cmd.stat_code = RS_ZERO;
					state_nxt     = ST_STAT;
				end else begin
					state_nxt = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_nxt    = ST_CAP;
			end
			ST_CAP: begin
				cmd.cap = 1'b1;
				if (sts.n_full || sts.rem_zero) begin
					state_nxt = ST_EMIT;
				end else begin
					state_nxt = ST_RD;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_data = 1'b1;
					state_nxt     = sts.rem_zero ? ST_IDLE : ST_RD;
				end
			end
			ST_STAT: begin
				if (sts.out_free) begin
					cmd.emit_stat = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/mrrb_dp.sv =====
// Datapath: byte store, write and publish registers, reader table, word packing, result register.
`default_nettype none
module mrrb_dp (
	input  logic                clk,
	input  logic                arst_n,
	mrrb_cfg_if.sink            cfg,
	mrrb_in_if.sink             item,
	mrrb_out_if.source          result,
	input  mrrb_pkg::ctrl_cmd_t cmd,
	output mrrb_pkg::dp_sts_t   sts
);
	import mrrb_pkg::*;

	// Configuration and write-side state.
	logic [SIZE_W-1:0] buf_size_q;
	logic [ADDR_W-1:0] wwp_q;
	logic [31:0]       wcnt_q;
	logic [ADDR_W-1:0] pwp_q;
	logic [31:0]       pcnt_q;

	// Per-reader state.
	logic [ADDR_W-1:0] rpos_q  [NUM_READERS];
	logic [31:0]       rseen_q [NUM_READERS];
	logic [NUM_READERS-1:0] rfirst_q;

	// Read transaction working registers.
	logic [SEL_W-1:0]  sel_q;
	logic [LEN_W-1:0]  req_q;
	logic [LEN_W-1:0]  al_q;
	logic [ADDR_W-1:0] rp_q;
	logic [LEN_W-1:0]  copy_q;
	logic [LEN_W-1:0]  rem_q;
	logic [CNT_W-1:0]  n_q;
	logic [63:0]       word_q;
	rd_status_t        stat_q;

	logic      out_valid_q;
	out_item_t out_q;

	logic [SIZE_W-1:0] size_eff;
	logic [ADDR_W-1:0] wp_cur;
	logic [SIZE_W-1:0] wp_inc;
	logic [ADDR_W-1:0] wp_next;
	logic [ADDR_W-1:0] rpos_sel;
	logic [ADDR_W-1:0] rp_n;
	logic [ADDR_W-1:0] wp_n;
	logic [SIZE_W-1:0] ready_b;
	logic [LEN_W-1:0]  req_sat;
	logic [LEN_W-1:0]  copy_raw;
	logic [LEN_W-1:0]  len;
	logic [SIZE_W-1:0] rp_inc;
	logic [ADDR_W-1:0] rp_adv;
	logic [7:0]        rdata;
	logic [LEN_W-1:0]  div_rem;
	logic              div_done;
	logic              item_fire;
	logic              cfg_fire;
	logic              sel_ok;
	logic              item_sel_ok;
	logic              out_free;
	logic              out_load;
	logic              commit_pos;

	assign cfg.ready   = 1'b1;
	assign item.ready  = cmd.in_ready;
	assign cfg_fire    = cfg.valid && cfg.ready;
	assign item_fire   = item.valid && item.ready;
	assign item_sel_ok = {1'b0, item.data.reader_sel} < (SEL_W + 1)'(NUM_READERS);
	assign sel_ok      = item_sel_ok;

	always_comb begin
		if (buf_size_q == '0) begin
			size_eff = SIZE_W'(1);
		end else if (buf_size_q > SIZE_W'(BUF_DEPTH)) begin
			size_eff = SIZE_W'(BUF_DEPTH);
		end else begin
			size_eff = buf_size_q;
		end

		wp_cur  = ({1'b0, wwp_q} >= size_eff) ? '0 : wwp_q;
		wp_inc  = {1'b0, wp_cur} + SIZE_W'(1);
		wp_next = (wp_inc >= size_eff) ? '0 : wp_inc[ADDR_W-1:0];

		rpos_sel = rpos_q[sel_q];
		rp_n     = ({1'b0, rpos_sel} >= size_eff) ? '0 : rpos_sel;
		wp_n     = ({1'b0, pwp_q} >= size_eff) ? '0 : pwp_q;
		if (rp_n < wp_n) begin
			ready_b = {1'b0, wp_n - rp_n};
		end else begin
			ready_b = size_eff - {1'b0, rp_n} + {1'b0, wp_n};
		end
		req_sat  = (req_q > LEN_W'(MAX_READ_BYTES)) ? LEN_W'(MAX_READ_BYTES) : req_q;
		copy_raw = (ready_b <= SIZE_W'(req_sat)) ? ready_b[LEN_W-1:0] : req_sat;

		len = (al_q == '0) ? copy_q : copy_q - div_rem;

		rp_inc = {1'b0, rp_q} + SIZE_W'(1);
		rp_adv = (rp_inc >= size_eff) ? '0 : rp_inc[ADDR_W-1:0];
	end

	assign out_free   = !out_valid_q || result.ready;
	assign out_load   = cmd.emit_data || cmd.emit_stat;
	assign commit_pos = (cmd.emit_stat && stat_q != RS_FIRST) ||
	                    (cmd.emit_data && rem_q == '0);

	assign sts.read_req = item.valid && item.data.op == OP_READ && sel_ok;
	assign sts.is_first = rfirst_q[sel_q];
	assign sts.no_new   = rp_n == wp_n && rseen_q[sel_q] == pcnt_q;
	assign sts.al_zero  = al_q == '0;
	assign sts.div_done = div_done;
	assign sts.len_zero = len == '0;
	assign sts.n_full   = n_q == CNT_W'(BYTES_PER_WORD - 1);
	assign sts.rem_zero = rem_q == '0;
	assign sts.out_free = out_free;

	mrrb_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (item_fire && item.data.op == OP_WRITE),
		.waddr(wp_cur),
		.wdata(item.data.wr_byte),
		.raddr(rp_q),
		.rdata(rdata)
	);

	mrrb_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(copy_raw),
		.divisor (al_q),
		.rem     (div_rem),
		.done    (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q  <= SIZE_W'(BUF_DEPTH);
			wwp_q       <= '0;
			wcnt_q      <= '0;
			pwp_q       <= '0;
			pcnt_q      <= '0;
			rfirst_q    <= '1;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_READERS; i++) begin
				rpos_q[i]  <= '0;
				rseen_q[i] <= '0;
			end
		end else begin
			if (cfg_fire) begin
				buf_size_q <= cfg.data;
				wwp_q      <= '0;
				pwp_q      <= '0;
			end else if (item_fire && item.data.op == OP_WRITE) begin
				wwp_q  <= wp_next;
				wcnt_q <= wcnt_q + 32'd1;
				if (item.data.wr_last) begin
					pwp_q  <= wp_next;
					pcnt_q <= wcnt_q + 32'd1;
				end
			end
			if (item_fire && item.data.op == OP_RESET && sel_ok) begin
				rfirst_q[item.data.reader_sel] <= 1'b1;
			end
			if (cmd.first_commit) begin
				rpos_q[sel_q]   <= pwp_q;
				rseen_q[sel_q]  <= pcnt_q;
				rfirst_q[sel_q] <= 1'b0;
			end
			if (cmd.seen_upd) begin
				rseen_q[sel_q] <= pcnt_q;
			end
			if (commit_pos) begin
				rpos_q[sel_q] <= rp_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			sel_q <= item.data.reader_sel;
			req_q <= item.data.req_size;
			al_q  <= item.data.align;
		end
		if (cmd.eval_load) begin
			rp_q   <= rp_n;
			copy_q <= copy_raw;
		end
		if (cmd.set_stat) begin
			stat_q <= cmd.stat_code;
		end
		if (cmd.len_load) begin
			rem_q  <= len;
			n_q    <= '0;
			word_q <= '0;
		end
		if (cmd.rd_issue) begin
			rp_q  <= rp_adv;
			rem_q <= rem_q - LEN_W'(1);
		end
		if (cmd.cap) begin
			for (int b = 0; b < BYTES_PER_WORD; b++) begin
				if (n_q[LANE_W-1:0] == LANE_W'(b)) begin
					word_q[b*8 +: 8] <= rdata;
				end
			end
			n_q <= n_q + CNT_W'(1);
		end
		if (cmd.emit_data) begin
			word_q               <= '0;
			n_q                  <= '0;
			out_q.status         <= RS_DATA;
			out_q.data_word      <= word_q;
			out_q.byte_count     <= n_q;
			out_q.last           <= rem_q == '0;
			out_q.total_count    <= pcnt_q;
			out_q.write_position <= pwp_q;
		end else if (cmd.emit_stat) begin
			out_q.status         <= stat_q;
			out_q.data_word      <= '0;
			out_q.byte_count     <= '0;
			out_q.last           <= 1'b1;
			out_q.total_count    <= pcnt_q;
			out_q.write_position <= pwp_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;
endmodule
`default_nettype wire

// ===== rtl/core/multi_reader_ring_buffer.sv =====
// Top level of the multi-reader ring buffer: controller, datapath and checks.
//
//  Channel  Dir  Handshake    Transaction content
//  cfg      in   valid/ready  buffer_size (17 bits), always ready
//  item     in   valid/ready  op, wr_byte, wr_last, reader_sel, req_size, align
//  result   out  valid/ready  status, data_word, byte_count, last, total_count,
//                             write_position
//
// A byte write, a reader reset or an ignored item is taken in the idle state.
// A read that answers with a first-read or no-new status passes the evaluate and
// status states plus any result stall; one that clamps to zero bytes also passes
// length state, and the divider if used. A data read passes evaluate, the alignment
// divider when align is nonzero, length, a read and a capture state per byte through
// the single store read port, and an emit per output word; a stalled result register
// holds the sequencer. Reset clears control state at once, not the byte store.
`default_nettype none
module multi_reader_ring_buffer (
	input  logic       clk,
	input  logic       arst_n,
	mrrb_cfg_if.sink   cfg,
	mrrb_in_if.sink    item,
	mrrb_out_if.source result
);
	import mrrb_pkg::*;

	`include "multi_reader_ring_buffer_assert.svh"

	// Commands from the sequencer and status back from the datapath.
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	mrrb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	mrrb_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.item  (item),
		.result(result),
		.cmd   (cmd),
		.sts   (sts)
	);

	// A result is loaded only when the result register is free.
	`MRRB_CHK_NOW(a_no_overwrite, cmd.emit_data || cmd.emit_stat, sts.out_free)
	// An accepted read transaction holds off further items in the next cycle.
	`MRRB_CHK_NEXT(a_read_blocks, item.valid && item.ready && sts.read_req, !item.ready)
	// Every store read is captured in the following cycle.
	`MRRB_CHK_NEXT(a_issue_capture, cmd.rd_issue, cmd.cap)
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the multi-reader ring buffer with a scoreboard and random traffic.
`default_nettype none

module tb_top;
	import mrrb_pkg::*;

	// The op code that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Cycles allowed after the last result before the block is taken as idle.
	localparam int SETTLE_CYCLES = 16;
	// The whole run is cut off here.
	localparam int CYCLE_LIMIT = 3000000;

	// The scoreboard mirrors the block's state and keeps the results it still owes.
	class ring_scoreboard;
		bit [7:0]    store_bytes [BUF_DEPTH];
		bit          store_valid [BUF_DEPTH];
		int unsigned size_reg;
		int unsigned work_pos;
		bit [31:0]   work_cnt;
		int unsigned pub_pos;
		bit [31:0]   pub_cnt;
		int unsigned rd_pos [NUM_READERS];
		bit [31:0]   rd_seen [NUM_READERS];
		bit          rd_first [NUM_READERS];
		out_item_t   owed_results [$];
		int          errors;

		function new();
			size_reg = BUF_DEPTH;
			work_pos = 0;
			work_cnt = 0;
			pub_pos = 0;
			pub_cnt = 0;
			errors = 0;
			for (int i = 0; i < NUM_READERS; i++) begin
				rd_pos[i] = 0;
				rd_seen[i] = 0;
				rd_first[i] = 1'b1;
			end
		endfunction

		// A zero size behaves as one, anything above the store depth as the full store.
		function int unsigned eff_size();
			if (size_reg == 0) return 1;
			if (size_reg > BUF_DEPTH) return BUF_DEPTH;
			return size_reg;
		endfunction

		function void set_size(int unsigned v);
			size_reg = v;
			work_pos = 0;
			pub_pos = 0;
		endfunction

		function void owe(rd_status_t st, bit [63:0] word, int unsigned n, bit fin);
			out_item_t r;
			r.status = st;
			r.data_word = word;
			r.byte_count = n[3:0];
			r.last = fin;
			r.total_count = pub_cnt;
			r.write_position = pub_pos[15:0];
			owed_results.push_back(r);
		endfunction

		// Length of the copy a read would make from reader sel, or -1 when nothing is
		// new. The start position is returned with stale positions already folded to zero.
		function int copy_len(int unsigned sel, int unsigned req, int unsigned al,
				output int unsigned rp);
			int unsigned size;
			int unsigned wp;
			int unsigned ready;
			int unsigned copy;
			size = eff_size();
			rp = rd_pos[sel];
			if (rp >= size) rp = 0;
			wp = pub_pos;
			if (wp >= size) wp = 0;
			if (rp == wp && rd_seen[sel] == pub_cnt) return -1;
			if (req > MAX_READ_BYTES) req = MAX_READ_BYTES;
			ready = (rp < wp) ? (wp - rp) : (size - rp + wp);
			copy = (ready <= req) ? ready : req;
			if (al > 0) copy = copy / al * al;
			return copy;
		endfunction

		// True when a read would touch no entry of the store that was never written.
		function bit read_safe(in_item_t it);
			int unsigned rp;
			int len;
			if (rd_first[it.reader_sel]) return 1'b1;
			len = copy_len(it.reader_sel, it.req_size, it.align, rp);
			for (int i = 0; i < len; i++) begin
				if (!store_valid[rp]) return 1'b0;
				rp++;
				if (rp >= eff_size()) rp = 0;
			end
			return 1'b1;
		endfunction

		function void note_item(in_item_t it);
			int unsigned size;
			int unsigned sel;
			int unsigned rp;
			int len;
			int i;
			int unsigned n;
			bit [63:0] word;
			size = eff_size();
			sel = it.reader_sel;
			case (it.op)
				OP_WRITE: begin
					if (work_pos >= size) work_pos = 0;
					store_bytes[work_pos] = it.wr_byte;
					store_valid[work_pos] = 1'b1;
					work_pos++;
					if (work_pos >= size) work_pos = 0;
					work_cnt++;
					if (it.wr_last) begin
						pub_pos = work_pos;
						pub_cnt = work_cnt;
					end
				end
				OP_RESET: rd_first[sel] = 1'b1;
				OP_READ: begin
					if (rd_first[sel]) begin
						rd_pos[sel] = pub_pos;
						rd_seen[sel] = pub_cnt;
						rd_first[sel] = 1'b0;
						owe(RS_FIRST, '0, 0, 1'b1);
					end else begin
						len = copy_len(sel, it.req_size, it.align, rp);
						if (len < 0) begin
							rd_pos[sel] = rp;
							owe(RS_NONE, '0, 0, 1'b1);
						end else begin
							rd_seen[sel] = pub_cnt;
							if (len == 0) begin
								rd_pos[sel] = rp;
								owe(RS_ZERO, '0, 0, 1'b1);
							end else begin
								i = 0;
								while (i < len) begin
									word = '0;
									n = 0;
									while (n < BYTES_PER_WORD && i < len) begin
										word[8*n +: 8] = store_bytes[rp];
										rp++;
										if (rp >= size) rp = 0;
										n++;
										i++;
									end
									owe(RS_DATA, word, n, i >= len);
								end
								rd_pos[sel] = rp;
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (owed_results.size() == 0) begin
				$error("result with nothing expected: status %0d word %h", got.status,
					got.data_word);
				errors++;
				return;
			end
			exp_r = owed_results.pop_front();
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, got.status);
				errors++;
			end
			if (got.data_word !== exp_r.data_word) begin
				$error("data_word: expected %h, got %h", exp_r.data_word, got.data_word);
				errors++;
			end
			if (got.byte_count !== exp_r.byte_count) begin
				$error("byte_count: expected %0d, got %0d", exp_r.byte_count,
					got.byte_count);
				errors++;
			end
			if (got.last !== exp_r.last) begin
				$error("last: expected %0d, got %0d", exp_r.last, got.last);
				errors++;
			end
			if (got.total_count !== exp_r.total_count) begin
				$error("total_count: expected %0d, got %0d", exp_r.total_count,
					got.total_count);
				errors++;
			end
			if (got.write_position !== exp_r.write_position) begin
				$error("write_position: expected %0d, got %0d", exp_r.write_position,
					got.write_position);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mrrb_cfg_if cfg_ch();
	mrrb_in_if  item_ch();
	mrrb_out_if result_ch();

	multi_reader_ring_buffer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch.sink),
		.item(item_ch.sink),
		.result(result_ch.source)
	);

	ring_scoreboard sb = new();

	// Sender burst bookkeeping, the receiver hold-off request and the write chunk state.
	int burst_left = 0;
	int hold_left = 0;
	int chunk_left = 0;
	int cycle_cnt = 0;

	// Every input of the block is known from time zero on.
	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
	end

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The run ends here if the block ever hangs.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("** multi_reader_ring_buffer: FAILED **");
			$finish;
		end
	end

	// The receiver picks a new stall pattern after each random stretch. Mode zero is a
	// stretch with no stall at all. A hold-off request from the stimulus keeps it
	// low for that many cycles so that the block backs up into its input.
	initial begin
		int mode;
		int mode_left;
		int period;
		int phase_cnt;
		mode = 0;
		mode_left = 0;
		period = 2;
		phase_cnt = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 80);
				period = $urandom_range(2, 7);
			end
			mode_left--;
			phase_cnt++;
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom_range(0, 1));
					2: result_ch.ready <= (phase_cnt % period) != 0;
					default: result_ch.ready <= (phase_cnt % period) == 0;
				endcase
			end
		end
	end

	// Every result transaction is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
	end

	// Offers one item and returns once the block has taken it. Between bursts the
	// valid line is held low for a random gap, which is sometimes skipped.
	task automatic send_raw(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 30);
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(it);
		burst_left--;
	endtask

	// A read that would reach store entries never written is preceded by a reset of
	// that reader, so its read becomes a first read instead.
	task automatic send_item(in_item_t it);
		in_item_t rst_it;
		if (it.op == OP_READ && !sb.read_safe(it)) begin
			rst_it = it;
			rst_it.op = OP_RESET;
			send_raw(rst_it);
		end
		send_raw(it);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic wait_drained();
		while (sb.owed_results.size() != 0) @(posedge clk);
	endtask

	// The size register is written only while the block is idle. Writes and resets
	// give no result, so SETTLE_CYCLES pass after the last result as well.
	task automatic write_size(int unsigned v);
		stop_sending();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v[SIZE_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_size(v);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic in_item_t make_item(logic [1:0] op, logic [7:0] b, logic fin,
			int unsigned sel, int unsigned req, int unsigned al);
		in_item_t it;
		it.op = op;
		it.wr_byte = b;
		it.wr_last = fin;
		it.reader_sel = sel[SEL_W-1:0];
		it.req_size = req[LEN_W-1:0];
		it.align = al[LEN_W-1:0];
		return it;
	endfunction

	// Random traffic is mostly chunked writes and reads with small request sizes,
	// with some saturating requests, odd alignments, reader resets and ignored ops.
	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		it.op = OP_WRITE;
		it.wr_byte = 8'($urandom());
		it.wr_last = 1'($urandom());
		it.reader_sel = SEL_W'($urandom());
		it.req_size = LEN_W'($urandom());
		it.align = LEN_W'($urandom());
		pick = $urandom_range(0, 99);
		if (chunk_left > 0 || pick < 50) begin
			if (chunk_left == 0) chunk_left = ($urandom_range(0, 9) == 0) ?
				$urandom_range(40, 120) : $urandom_range(1, 24);
			chunk_left--;
			it.op = OP_WRITE;
			it.wr_last = (chunk_left == 0);
		end else if (pick < 90) begin
			it.op = OP_READ;
			case ($urandom_range(0, 9))
				0: it.req_size = LEN_W'($urandom());
				1: it.req_size = LEN_W'($urandom_range(0, 512));
				default: it.req_size = LEN_W'($urandom_range(0, 64));
			endcase
			case ($urandom_range(0, 9))
				0: it.align = LEN_W'($urandom());
				1, 2: it.align = LEN_W'($urandom_range(1, 9));
				default: it.align = '0;
			endcase
		end else if (pick < 95) begin
			it.op = OP_RESET;
		end else begin
			it.op = OP_UNUSED;
		end
		return it;
	endfunction

	// Random items for one setting of the size register. Ignored items do not count.
	// Half way through, the sender either waits for every owed result or the
	// receiver is told to hold off for a long stretch while items keep coming.
	task automatic random_phase(int n_items, bit long_hold);
		in_item_t it;
		int done;
		done = 0;
		while (done < n_items) begin
			if (done == n_items / 2) begin
				if (long_hold) hold_left = 600;
				else begin
					stop_sending();
					wait_drained();
				end
			end
			it = random_item();
			send_item(it);
			if (it.op != OP_UNUSED) done++;
		end
	endtask

	initial begin
		int unsigned sizes [6];
		sizes = '{17, 1, 0, 131071, 300, 65536};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at the reset size: the first read, nothing new, bytes that are
		// not yet published, a zero request, a saturated request, alignment that rounds
		// down and one that leaves nothing, a reader reset and an ignored op.
		send_item(make_item(OP_READ, 8'h00, 1'b0, 0, 16, 0));
		send_item(make_item(OP_READ, 8'h00, 1'b0, 0, 16, 0));
		send_item(make_item(OP_WRITE, 8'h00, 1'b0, 0, 0, 0));
		send_item(make_item(OP_WRITE, 8'hFF, 1'b0, 7, 1023, 1023));
		send_item(make_item(OP_READ, 8'h00, 1'b0, 0, 16, 0));
		send_item(make_item(OP_WRITE, 8'hA5, 1'b1, 0, 0, 0));
		send_item(make_item(OP_READ, 8'h00, 1'b0, 0, 0, 0));
		send_item(make_item(OP_READ, 8'hFF, 1'b1, 0, 1023, 0));
		for (int i = 0; i < 12; i++)
			send_item(make_item(OP_WRITE, 8'(8'h11 * i), i == 11, 0, 0, 0));
		send_item(make_item(OP_READ, 8'h00, 1'b0, 7, 512, 0));
		send_item(make_item(OP_READ, 8'h00, 1'b0, 0, 512, 5));
		send_item(make_item(OP_READ, 8'h00, 1'b0, 0, 512, 1023));
		send_item(make_item(OP_RESET, 8'h00, 1'b0, 0, 0, 0));
		send_item(make_item(OP_READ, 8'h00, 1'b0, 0, 8, 0));
		send_item(make_item(OP_UNUSED, 8'hFF, 1'b1, 7, 1023, 1023));

		random_phase(60, 1'b0);
		// Each new size also leaves reader positions that may lie beyond the store.
		foreach (sizes[k]) begin
			write_size(sizes[k]);
			random_phase(50, k == 0 || k == 4);
		end

		stop_sending();
		wait_drained();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.owed_results.size() == 0) begin
			$display("** multi_reader_ring_buffer: PASSED **");
		end else begin
			$display("** multi_reader_ring_buffer: FAILED **");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mrrb_pkg.sv
rtl/core/mrrb_ifs.sv
rtl/core/mrrb_ram.sv
rtl/core/mrrb_div.sv
rtl/core/mrrb_ctrl.sv
rtl/core/mrrb_dp.sv
rtl/core/multi_reader_ring_buffer.sv
tb/sv/tb_top.sv
